[rtl/msfcc_pkg.sv]
package msfcc_pkg;

  localparam logic [24:0] CRC_GEN         = 25'h1FFF409;
  localparam logic [31:0] LONG_LAST_MASK  = 32'hFFFF0000;
  localparam logic [31:0] SHORT_LAST_MASK = 32'hFFFFFF00;
  localparam logic [23:0] MASK24          = 24'hFFFFFF;

  // Downlink formats whose parity is overlaid with the address
  localparam logic [4:0] DF_SHORT_SURV = 5'd0;
  localparam logic [4:0] DF_ALT_REPLY  = 5'd4;
  localparam logic [4:0] DF_ID_REPLY   = 5'd5;

  typedef struct packed {
    logic [31:0] word;
    logic        last_word;
  } in_t;

  typedef struct packed {
    logic        length_ok;
    logic [4:0]  downlink_format;
    logic [23:0] aircraft_address;
    logic        frame_valid;
    logic [23:0] syndrome;
  } out_t;

  // Word class set by the front end
  typedef enum logic [1:0] {
    KIND_MID,
    KIND_LAST_SHORT,
    KIND_LAST_LONG,
    KIND_LAST_BAD
  } kind_t;

  typedef struct packed {
    logic [31:0] word;
    logic        first;
    kind_t       kind;
  } cmd_t;

  // Shift the top nbits of w through the CRC-24 remainder (linear XOR network)
  function automatic logic [23:0] crc_bits(logic [23:0] rem_in, logic [31:0] w,
                                           logic [5:0] nbits);
    logic [24:0] r;
    r = {1'b0, rem_in};
    for (int i = 0; i < 32; i++) begin
      if (6'(i) < nbits) begin
        r = {r[23:0], w[31 - i]};
        if (r[24]) begin
          r = r ^ CRC_GEN;
        end
      end
    end
    return r[23:0];
  endfunction

endpackage

[rtl/msfcc_front.sv]
module msfcc_front
  import msfcc_pkg::*;
#(
  parameter int MAX_WORDS = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  localparam int CW = $clog2(MAX_WORDS + 1);

  logic [CW-1:0] word_count;
  logic [CW-1:0] word_count_next;
  logic          take;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign take      = in_valid && cmd_ready;

  // Classify the word by its position in the frame
  always_comb begin
    cmd.word  = in_data.word;
    cmd.first = (word_count == '0);
    if (!in_data.last_word) begin
      cmd.kind = KIND_MID;
    end else if (word_count == CW'(1)) begin
      cmd.kind = KIND_LAST_SHORT;
    end else if (word_count == CW'(3)) begin
      cmd.kind = KIND_LAST_LONG;
    end else begin
      cmd.kind = KIND_LAST_BAD;
    end
  end

  // Saturating word counter, cleared at end of frame
  always_comb begin
    word_count_next = word_count;
    if (take) begin
      if (in_data.last_word) begin
        word_count_next = '0;
      end else if (word_count < CW'(MAX_WORDS)) begin
        word_count_next = word_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
    end else begin
      word_count <= word_count_next;
    end
  end

endmodule

[rtl/msfcc_fifo.sv]
module msfcc_fifo
  import msfcc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

[rtl/msfcc_back.sv]
module msfcc_back
  import msfcc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic [23:0] crc_remainder;
  logic [23:0] crc_remainder_next;
  logic [28:0] fields;
  logic [28:0] fields_next;
  logic [23:0] rem_base;
  logic [28:0] fields_cur;
  logic [23:0] syn;
  logic [4:0]  df;
  logic        take;
  logic        is_last;
  out_t        result;

  assign cmd_ready = !out_valid || out_ready;
  assign take      = cmd_valid && cmd_ready;
  assign is_last   = (cmd.kind != KIND_MID);

  // Frame start restarts the remainder and latches DF and address
  always_comb begin
    rem_base   = cmd.first ? '0 : crc_remainder;
    fields_cur = cmd.first ? {cmd.word[31:27], cmd.word[23:0]} : fields;
    df         = fields_cur[28:24];
  end

  // Remainder update and final syndrome
  always_comb begin
    case (cmd.kind)
      KIND_LAST_SHORT: syn = crc_bits(rem_base, cmd.word & SHORT_LAST_MASK, 6'd24);
      KIND_LAST_LONG:  syn = crc_bits(rem_base, cmd.word & LONG_LAST_MASK, 6'd16);
      default:         syn = crc_bits(rem_base, cmd.word, 6'd32);
    endcase
  end

  // Result fields
  always_comb begin
    result = '0;
    if (cmd.kind == KIND_LAST_SHORT || cmd.kind == KIND_LAST_LONG) begin
      result.length_ok       = 1'b1;
      result.downlink_format = df;
      result.syndrome        = syn;
      if (df == DF_SHORT_SURV || df == DF_ALT_REPLY || df == DF_ID_REPLY) begin
        result.aircraft_address = syn;
        result.frame_valid      = 1'b0;
      end else begin
        result.aircraft_address = fields_cur[23:0] & MASK24;
        result.frame_valid      = (syn == '0);
      end
    end
  end

  always_comb begin
    crc_remainder_next = crc_remainder;
    fields_next        = fields;
    if (take) begin
      if (is_last) begin
        crc_remainder_next = '0;
        fields_next        = '0;
      end else begin
        crc_remainder_next = syn;
        fields_next        = fields_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_remainder <= '0;
      fields        <= '0;
    end else begin
      crc_remainder <= crc_remainder_next;
      fields        <= fields_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && is_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_last) begin
      out_data <= result;
    end
  end

endmodule

[rtl/mode_s_frame_crc_check_unit.sv]
// Path: the frame's last word request is held in a queue entry, then the output
// register, before out_valid rises; an output stall can hold it in the queue.
// Throughput: one word per cycle if out_ready holds; 32-bit parallel CRC-24 update
// in the back end; a 2-entry queue between front and back absorbs short stalls.
// Reset: synchronous active-high rst clears the word counter, queue, CRC remainder
// and output valid; no item is in flight after reset.
module mode_s_frame_crc_check_unit
  import msfcc_pkg::*;
#(
  parameter int MAX_WORDS = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic fr_valid;
  logic fr_ready;
  cmd_t fr_cmd;
  logic bk_valid;
  logic bk_ready;
  cmd_t bk_cmd;

  msfcc_front #(
    .MAX_WORDS(MAX_WORDS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_valid(fr_valid),
    .cmd_ready(fr_ready),
    .cmd      (fr_cmd)
  );

  msfcc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fr_valid),
    .push_ready(fr_ready),
    .push_data (fr_cmd),
    .pop_valid (bk_valid),
    .pop_ready (bk_ready),
    .pop_data  (bk_cmd)
  );

  msfcc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(bk_valid),
    .cmd_ready(bk_ready),
    .cmd      (bk_cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

[test/mode_s_frame_crc_check_unit_test.sv]
module mode_s_frame_crc_check_unit_test;
  import msfcc_pkg::*;

  // Downlink formats used to steer random frames (the others come from the package)
  localparam logic [4:0] DF_ALL_CALL  = 5'd11;
  localparam logic [4:0] DF_EXT_SQUIT = 5'd17;

  // Word counter saturation of the block under its default parameter
  localparam int SAT_WORDS     = 4;
  localparam int RANDOM_WORDS  = 1800;
  localparam int MAX_REPORTS   = 50;

  typedef struct {
    logic [31:0] word;
    logic        last;
    bit          typed;
    out_t        result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Hand-written verdict that travels alongside a directed request
  bit   row_typed;
  out_t row_result;

  bit quiet = 1'b0;

  // Predictor state: running remainder and first-word fields of the open frame
  logic [23:0] crc_acc = '0;
  int          words_seen = 0;
  logic [4:0]  lead_df = '0;
  logic [23:0] lead_addr = '0;

  out_t      pending_verdicts[$];
  stim_row_t directed_rows[$];

  int fail_count = 0;
  int items_sent = 0;
  int words_taken = 0;
  int short_frames = 0;
  int long_frames = 0;
  int bad_frames = 0;
  int verdicts_checked = 0;
  int clean_parity = 0;

  mode_s_frame_crc_check_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // Polynomial division of the top nbits of w, MSB first
  function automatic logic [23:0] crc24_shift(logic [23:0] acc, logic [31:0] w, int nbits);
    logic msb;
    for (int i = 0; i < nbits; i++) begin
      msb = acc[23];
      acc = {acc[22:0], w[31 - i]};
      if (msb) begin
        acc = acc ^ CRC_GEN[23:0];
      end
    end
    return acc;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < MAX_REPORTS) begin
      $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
    end
    fail_count++;
  endtask

  // Advance the predictor by one accepted word; queue a verdict on the last word
  task automatic judge_word(input in_t item, input bit typed, input out_t typed_res);
    out_t        v;
    logic [23:0] syn;
    words_taken++;
    if (words_seen == 0) begin
      lead_df   = item.word[31:27];
      lead_addr = item.word[23:0];
    end
    if (!item.last_word) begin
      crc_acc = crc24_shift(crc_acc, item.word, 32);
      if (words_seen < SAT_WORDS) begin
        words_seen++;
      end
    end else begin
      v = '0;
      if (words_seen == 1 || words_seen == 3) begin
        // short reply keeps 24 bits of the last word, long reply 16
        syn = crc24_shift(crc_acc, item.word, (words_seen == 3) ? 16 : 24);
        v.length_ok       = 1'b1;
        v.downlink_format = lead_df;
        v.syndrome        = syn;
        if (lead_df inside {DF_SHORT_SURV, DF_ALT_REPLY, DF_ID_REPLY}) begin
          v.aircraft_address = syn;
        end else begin
          v.aircraft_address = lead_addr;
          v.frame_valid      = (syn == '0);
        end
        if (words_seen == 1) short_frames++;
        else long_frames++;
      end else begin
        bad_frames++;
      end
      if (typed) begin
        v = typed_res;
      end
      pending_verdicts.push_back(v);
      crc_acc    = '0;
      words_seen = 0;
      lead_df    = '0;
      lead_addr  = '0;
    end
  endtask

  // Check delivered verdicts, then record accepted requests
  always @(posedge clk) begin : watch
    out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("verdict with nothing pending", 32'(out_data.syndrome), '0);
        end else begin
          want = pending_verdicts.pop_front();
          verdicts_checked++;
          if (out_data.frame_valid === 1'b1) clean_parity++;
          if (out_data.length_ok !== want.length_ok)
            report_mismatch("length_ok", 32'(out_data.length_ok), 32'(want.length_ok));
          if (out_data.downlink_format !== want.downlink_format)
            report_mismatch("downlink_format", 32'(out_data.downlink_format),
                            32'(want.downlink_format));
          if (out_data.aircraft_address !== want.aircraft_address)
            report_mismatch("aircraft_address", 32'(out_data.aircraft_address),
                            32'(want.aircraft_address));
          if (out_data.frame_valid !== want.frame_valid)
            report_mismatch("frame_valid", 32'(out_data.frame_valid),
                            32'(want.frame_valid));
          if (out_data.syndrome !== want.syndrome)
            report_mismatch("syndrome", 32'(out_data.syndrome), 32'(want.syndrome));
        end
      end
      if (in_valid && in_ready) begin
        judge_word(in_data, row_typed, row_result);
      end
    end
  end

  // Receiver stalls about a third of the time, except in the quiet stretch
  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 33);
  end

  // One word request; entered and left at a falling edge
  task automatic send_word(input logic [31:0] w, input logic last, input bit typed,
                           input out_t res);
    while (!quiet && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= '{word: w, last_word: last};
    row_typed  <= typed;
    row_result <= res;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    items_sent++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending_verdicts.size() != 0);
  endtask

  task automatic add_row(input logic [31:0] w, input logic last, input bit typed,
                         input out_t res);
    stim_row_t r;
    r.word   = w;
    r.last   = last;
    r.typed  = typed;
    r.result = res;
    directed_rows.push_back(r);
  endtask

  // Random frame: mostly 2 or 4 words with patched parity, some corrupted or raw
  task automatic send_random_frame();
    logic [31:0] fw [12];
    logic [23:0] par;
    int          n;
    int          mode;
    int          j;
    int          b;
    if ($urandom_range(99) < 80) begin
      n = ($urandom_range(1) == 0) ? 2 : 4;
    end else begin
      j = $urandom_range(9);
      n = (j == 0) ? 1 : (j == 1) ? 3 : j + 3;
    end
    foreach (fw[k]) fw[k] = $urandom();
    case ($urandom_range(7))
      0: fw[0][31:27] = DF_SHORT_SURV;
      1: fw[0][31:27] = DF_ALT_REPLY;
      2: fw[0][31:27] = DF_ID_REPLY;
      3: fw[0][31:27] = DF_ALL_CALL;
      4: fw[0][31:27] = DF_EXT_SQUIT;
      default: ;
    endcase
    mode = $urandom_range(3);
    if ((n == 2 || n == 4) && mode != 3) begin
      // syndrome is linear in the parity field, so zero it and fold the remainder back in
      if (n == 2) begin
        fw[1][31:8] = '0;
      end else begin
        fw[2][7:0]   = '0;
        fw[3][31:16] = '0;
      end
      par = '0;
      for (int k = 0; k < n - 1; k++) par = crc24_shift(par, fw[k], 32);
      par = crc24_shift(par, fw[n - 1], (n == 2) ? 24 : 16);
      if (n == 2) begin
        fw[1][31:8] = par;
      end else begin
        fw[2][7:0]   = par[23:16];
        fw[3][31:16] = par[15:0];
      end
      // single bit error in a kept bit
      if (mode == 2) begin
        j = $urandom_range(n - 1);
        b = 16 + $urandom_range(15);
        fw[j][b] = ~fw[j][b];
      end
    end
    for (int k = 0; k < n; k++) begin
      send_word(fw[k], k == n - 1, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    out_t len_err;
    out_t zero_short;
    int   base;
    bit   drained_mid;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    row_typed  = 1'b0;
    row_result = '0;
    drained_mid = 1'b0;
    len_err    = '0;
    zero_short = out_t'{1'b1, 5'd0, 24'd0, 1'b0, 24'd0};

    // lone word closed at once: length error
    add_row(32'hFFFF_FFFF, 1'b1, 1'b1, len_err);
    // three-word frame: length error
    add_row(32'h5D00_0000, 1'b0, 1'b0, '0);
    add_row(32'hFFFF_FFFF, 1'b0, 1'b0, '0);
    add_row(32'h1234_5678, 1'b1, 1'b1, len_err);
    // all-zero short reply: DF0, zero syndrome reported as address
    add_row(32'h0000_0000, 1'b0, 1'b0, '0);
    add_row(32'h0000_0000, 1'b1, 1'b1, zero_short);
    // all-ones long reply, DF31, low half of last word dropped
    add_row(32'hFFFF_FFFF, 1'b0, 1'b0, '0);
    add_row(32'hFFFF_FFFF, 1'b0, 1'b0, '0);
    add_row(32'hFFFF_FFFF, 1'b0, 1'b0, '0);
    add_row(32'hFFFF_FFFF, 1'b1, 1'b0, '0);
    // extended squitter with good parity and dirty dropped bits
    add_row(32'h8D48_40D6, 1'b0, 1'b0, '0);
    add_row(32'h202C_C371, 1'b0, 1'b0, '0);
    add_row(32'hC32C_E057, 1'b0, 1'b0, '0);
    add_row(32'h6098_ABCD, 1'b1, 1'b0, '0);
    // all-call reply, full 24-bit syndrome, dirty low byte
    add_row(32'h5D48_4FDE, 1'b0, 1'b0, '0);
    add_row(32'hA248_F5FF, 1'b1, 1'b0, '0);
    // altitude and identity replies: address overlaid on parity
    add_row(32'h2000_1234, 1'b0, 1'b0, '0);
    add_row(32'h9ABC_DE00, 1'b1, 1'b0, '0);
    add_row(32'h28AB_CDEF, 1'b0, 1'b0, '0);
    add_row(32'h00FF_00FF, 1'b1, 1'b0, '0);
    // overlong frame: counter saturates, still a length error
    add_row(32'h5800_0001, 1'b0, 1'b0, '0);
    add_row(32'hA5A5_A5A5, 1'b0, 1'b0, '0);
    add_row(32'h5A5A_5A5A, 1'b0, 1'b0, '0);
    add_row(32'h0F0F_0F0F, 1'b0, 1'b0, '0);
    add_row(32'hF0F0_F0F0, 1'b0, 1'b0, '0);
    add_row(32'h1357_9BDF, 1'b1, 1'b1, len_err);

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].result);
    end
    hold_until_drained();

    // random frames, with a stall-free stretch and a mid-run drain
    base = items_sent;
    while (items_sent < base + RANDOM_WORDS) begin
      quiet = (items_sent - base >= 600) && (items_sent - base < 900);
      if (!drained_mid && items_sent - base >= 1200) begin
        hold_until_drained();
        drained_mid = 1'b1;
      end
      send_random_frame();
    end
    quiet = 1'b0;
    hold_until_drained();
    repeat (8) @(negedge clk);

    if (pending_verdicts.size() != 0) begin
      report_mismatch("verdicts never delivered", 32'(pending_verdicts.size()), '0);
    end
    $display("sent %0d words: %0d short, %0d long and %0d bad-length frames",
             words_taken, short_frames, long_frames, bad_frames);
    $display("%0d verdicts checked, %0d with clean parity, %0d mismatches",
             verdicts_checked, clean_parity, fail_count);
    if (fail_count == 0) begin
      $display("mode_s_frame_crc_check_unit_test passed");
    end else begin
      $display("mode_s_frame_crc_check_unit_test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("timeout with %0d verdicts pending", pending_verdicts.size());
    $display("mode_s_frame_crc_check_unit_test failed");
    $finish;
  end

endmodule
